// ===== rtl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg
// shared types and constants of the vector normalize pipeline
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int C_LANES     = 3;
    localparam int C_COMP_W    = 32;
    localparam int C_SUM_W     = 64;
    localparam int C_ROOT_W    = C_SUM_W / 2;
    localparam int C_REM_W     = C_ROOT_W + 4;
    localparam int C_QUOT_W    = 31;
    localparam int C_DREM_W    = C_COMP_W + 1;
    localparam int C_SQ_STAGES = C_ROOT_W;
    localparam int C_DV_STAGES = C_QUOT_W;

    typedef logic [C_COMP_W-1:0] t_mag;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [C_LANES-1:0] neg;
    } t_side;

endpackage

// ===== rtl/vector3_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// normalizes one q15.16 3-d vector to q1.30 and returns its q16.16 length
// ----------------------------------------------------------------------------
// Accepts one request per clock while o_stall is low and returns one result per
// request, in order. The pipeline is the magnitude register, the register of the
// three 32x32 squares, the 64-bit sum register, the bit-per-stage square root,
// the bit-per-stage divider (three lanes side by side) and one output register.
// The whole pipeline holds while a result waits under output stall, so o_stall
// follows i_stall only when the output register is full.
module vector3_normalize_unit import v3n_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_unit_x,
    output logic signed [31:0]  o_unit_y,
    output logic signed [31:0]  o_unit_z,
    output logic        [31:0]  o_length,
    output logic                o_was_zero
);

    logic w_adv;

    t_side                r_p0_side, r_p1_side, r_p2_side;
    t_mag                 r_p0_mag [C_LANES];
    t_mag                 r_p1_mag [C_LANES];
    t_mag                 r_p2_mag [C_LANES];
    logic [C_SUM_W-1:0]   r_p1_sq  [C_LANES];
    logic [C_SUM_W-1:0]   r_p2_sum;

    t_side                r_sq_side [C_SQ_STAGES];
    t_mag                 r_sq_mag  [C_SQ_STAGES][C_LANES];
    logic [C_SUM_W-1:0]   r_sq_s    [C_SQ_STAGES];
    logic [C_REM_W-1:0]   r_sq_r    [C_SQ_STAGES];
    logic [C_ROOT_W-1:0]  r_sq_q    [C_SQ_STAGES];
    logic [C_SUM_W-1:0]   n_sq_s    [C_SQ_STAGES];
    logic [C_REM_W-1:0]   n_sq_r    [C_SQ_STAGES];
    logic [C_ROOT_W-1:0]  n_sq_q    [C_SQ_STAGES];

    t_side                r_dv_side [C_DV_STAGES];
    logic [C_ROOT_W-1:0]  r_dv_len  [C_DV_STAGES];
    logic [C_DREM_W-1:0]  r_dv_rem  [C_DV_STAGES][C_LANES];
    logic [C_QUOT_W-1:0]  r_dv_quo  [C_DV_STAGES][C_LANES];
    logic [C_DREM_W-1:0]  n_dv_rem  [C_DV_STAGES][C_LANES];
    logic [C_QUOT_W-1:0]  n_dv_quo  [C_DV_STAGES][C_LANES];

    logic                 r_out_valid;
    logic [31:0]          r_out_unit [C_LANES];
    logic [31:0]          r_out_len;
    logic                 r_out_zero;
    logic [31:0]          n_out_unit [C_LANES];

    logic [C_COMP_W-1:0]  w_in [C_LANES];

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;
    assign w_in[0] = i_in_x;
    assign w_in[1] = i_in_y;
    assign w_in[2] = i_in_z;

    // square root stages, two radicand bits per stage
    always_comb begin
        logic [C_SUM_W-1:0]  s_in;
        logic [C_REM_W-1:0]  r_in;
        logic [C_ROOT_W-1:0] q_in;
        logic [C_REM_W-1:0]  rr;
        logic [C_REM_W-1:0]  tt;
        for (int i = 0; i < C_SQ_STAGES; i++) begin
            if (i == 0) begin
                s_in = r_p2_sum;
                r_in = '0;
                q_in = '0;
            end else begin
                s_in = r_sq_s[i-1];
                r_in = r_sq_r[i-1];
                q_in = r_sq_q[i-1];
            end
            rr = {r_in[C_REM_W-3:0], s_in[C_SUM_W-1 -: 2]};
            tt = {2'b00, q_in, 2'b01};
            n_sq_s[i] = {s_in[C_SUM_W-3:0], 2'b00};
            if (rr >= tt) begin
                n_sq_r[i] = rr - tt;
                n_sq_q[i] = {q_in[C_ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_r[i] = rr;
                n_sq_q[i] = {q_in[C_ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divide stages, one quotient bit per stage and lane
    always_comb begin
        logic [C_DREM_W-1:0] d;
        logic [C_DREM_W-1:0] dl;
        logic [C_QUOT_W-1:0] q_in;
        for (int j = 0; j < C_DV_STAGES; j++) begin
            for (int k = 0; k < C_LANES; k++) begin
                if (j == 0) begin
                    d    = {1'b0, r_sq_mag[C_SQ_STAGES-1][k]};
                    dl   = {1'b0, r_sq_q[C_SQ_STAGES-1]};
                    q_in = '0;
                end else begin
                    d    = {r_dv_rem[j-1][k][C_DREM_W-2:0], 1'b0};
                    dl   = {1'b0, r_dv_len[j-1]};
                    q_in = r_dv_quo[j-1][k];
                end
                if (d >= dl) begin
                    n_dv_rem[j][k] = d - dl;
                    n_dv_quo[j][k] = {q_in[C_QUOT_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[j][k] = d;
                    n_dv_quo[j][k] = {q_in[C_QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < C_LANES; k++) begin
            if (r_dv_side[C_DV_STAGES-1].zero) begin
                n_out_unit[k] = '0;
            end else if (r_dv_side[C_DV_STAGES-1].neg[k]) begin
                n_out_unit[k] = 32'd0 - {1'b0, r_dv_quo[C_DV_STAGES-1][k]};
            end else begin
                n_out_unit[k] = {1'b0, r_dv_quo[C_DV_STAGES-1][k]};
            end
        end
    end

    // pipeline registers, only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_side.valid <= 1'b0;
            r_p1_side.valid <= 1'b0;
            r_p2_side.valid <= 1'b0;
            for (int i = 0; i < C_SQ_STAGES; i++) begin
                r_sq_side[i].valid <= 1'b0;
            end
            for (int j = 0; j < C_DV_STAGES; j++) begin
                r_dv_side[j].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_p0_side.valid <= i_valid;
            r_p1_side.valid <= r_p0_side.valid;
            r_p2_side.valid <= r_p1_side.valid;
            r_sq_side[0].valid <= r_p2_side.valid;
            for (int i = 1; i < C_SQ_STAGES; i++) begin
                r_sq_side[i].valid <= r_sq_side[i-1].valid;
            end
            r_dv_side[0].valid <= r_sq_side[C_SQ_STAGES-1].valid;
            for (int j = 1; j < C_DV_STAGES; j++) begin
                r_dv_side[j].valid <= r_dv_side[j-1].valid;
            end
            r_out_valid <= r_dv_side[C_DV_STAGES-1].valid;

            for (int k = 0; k < C_LANES; k++) begin
                r_p0_mag[k]     <= w_in[k][C_COMP_W-1] ? (~w_in[k] + 32'd1) : w_in[k];
                r_p0_side.neg[k] <= w_in[k][C_COMP_W-1];
                r_p1_sq[k]      <= {32'd0, r_p0_mag[k]} * {32'd0, r_p0_mag[k]};
                r_p1_mag[k]     <= r_p0_mag[k];
                r_p2_mag[k]     <= r_p1_mag[k];
            end
            r_p0_side.zero <= 1'b0;
            r_p1_side.neg  <= r_p0_side.neg;
            r_p1_side.zero <= 1'b0;
            r_p2_sum       <= r_p1_sq[0] + r_p1_sq[1] + r_p1_sq[2];
            r_p2_side.neg  <= r_p1_side.neg;
            r_p2_side.zero <= (r_p1_sq[0] == '0) && (r_p1_sq[1] == '0)
                              && (r_p1_sq[2] == '0);

            for (int i = 0; i < C_SQ_STAGES; i++) begin
                r_sq_s[i] <= n_sq_s[i];
                r_sq_r[i] <= n_sq_r[i];
                r_sq_q[i] <= n_sq_q[i];
                if (i == 0) begin
                    r_sq_side[i].neg  <= r_p2_side.neg;
                    r_sq_side[i].zero <= r_p2_side.zero;
                    r_sq_mag[i]       <= r_p2_mag;
                end else begin
                    r_sq_side[i].neg  <= r_sq_side[i-1].neg;
                    r_sq_side[i].zero <= r_sq_side[i-1].zero;
                    r_sq_mag[i]       <= r_sq_mag[i-1];
                end
            end

            for (int j = 0; j < C_DV_STAGES; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_quo[j] <= n_dv_quo[j];
                if (j == 0) begin
                    r_dv_side[j].neg  <= r_sq_side[C_SQ_STAGES-1].neg;
                    r_dv_side[j].zero <= r_sq_side[C_SQ_STAGES-1].zero;
                    r_dv_len[j]       <= r_sq_q[C_SQ_STAGES-1];
                end else begin
                    r_dv_side[j].neg  <= r_dv_side[j-1].neg;
                    r_dv_side[j].zero <= r_dv_side[j-1].zero;
                    r_dv_len[j]       <= r_dv_len[j-1];
                end
            end

            r_out_unit <= n_out_unit;
            r_out_len  <= r_dv_len[C_DV_STAGES-1];
            r_out_zero <= r_dv_side[C_DV_STAGES-1].zero;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_unit_x   = r_out_unit[0];
    assign o_unit_y   = r_out_unit[1];
    assign o_unit_z   = r_out_unit[2];
    assign o_length   = r_out_len;
    assign o_was_zero = r_out_zero;

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_was_zero == (o_length == 32'd0)))
        else $error("zero flag and length disagree");

    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_zero) |-> (o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0))
        else $error("zero vector gave nonzero units");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x <= 32'sh4000_0000 && o_unit_x >= -32'sh4000_0000))
        else $error("unit x out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_sq_q[C_SQ_STAGES-1]) && $stable(r_dv_len[0]))
        else $error("pipeline moved while held");

endmodule
